// ----- design/pse_pkg.sv -----
// Shared types, constants and helpers for the polynomial shift engine.
// Depends on nothing; used by pse_ctrl, pse_datapath, the top level, the checker and the testbench.
package pse_pkg;

	// Index and count widths cover the full supported store depth (up to 16)
	localparam int TIDX_W = 4;
	localparam int CNT_W  = 5;

	// 48-bit signed limits held in a 64-bit signed word
	localparam logic signed [63:0] SAT_MAX = 64'sh0000_7FFF_FFFF_FFFF;
	localparam logic signed [63:0] SAT_MIN = 64'shFFFF_8000_0000_0000;

	// Coefficient request
	typedef struct packed {
		logic signed [47:0] coefficient;
		logic signed [31:0] shift_amount;
		logic               last_term;
	} pse_in_t;

	// Result request
	typedef struct packed {
		logic signed [47:0] shifted_coefficient;
		logic               end_of_set;
		logic               overflow_flag;
	} pse_out_t;

	// Datapath operation for one phase of a Horner step
	typedef enum logic [2:0] {
		OP_NONE,
		OP_MAG,
		OP_MLO,
		OP_MHI,
		OP_RND,
		OP_ACC
	} pse_op_t;

	// Controller to datapath
	typedef struct packed {
		logic              load;
		logic              first_step;
		pse_op_t           op;
		logic              emit;
		logic              last_row;
		logic [TIDX_W-1:0] row;
		logic [TIDX_W-1:0] term;
	} pse_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic [CNT_W-1:0] term_count;
		logic             out_free;
	} pse_stat_t;

	// Saturated value with its overflow mark
	typedef struct packed {
		logic               ovf;
		logic signed [47:0] val;
	} pse_sat_t;

	// Pascal triangle, row k holds C(k, 0..k)
	localparam logic [12:0] PASCAL_TBL [16][16] = '{
		'{1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{1, 2, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{1, 3, 3, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{1, 4, 6, 4, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{1, 5, 10, 10, 5, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{1, 6, 15, 20, 15, 6, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{1, 7, 21, 35, 35, 21, 7, 1, 0, 0, 0, 0, 0, 0, 0, 0},
		'{1, 8, 28, 56, 70, 56, 28, 8, 1, 0, 0, 0, 0, 0, 0, 0},
		'{1, 9, 36, 84, 126, 126, 84, 36, 9, 1, 0, 0, 0, 0, 0, 0},
		'{1, 10, 45, 120, 210, 252, 210, 120, 45, 10, 1, 0, 0, 0, 0, 0},
		'{1, 11, 55, 165, 330, 462, 462, 330, 165, 55, 11, 1, 0, 0, 0, 0},
		'{1, 12, 66, 220, 495, 792, 924, 792, 495, 220, 66, 12, 1, 0, 0, 0},
		'{1, 13, 78, 286, 715, 1287, 1716, 1716, 1287, 715, 286, 78, 13, 1, 0, 0},
		'{1, 14, 91, 364, 1001, 2002, 3003, 3432, 3003, 2002, 1001, 364, 91, 14, 1, 0},
		'{1, 15, 105, 455, 1365, 3003, 5005, 6435, 6435, 5005, 3003, 1365, 455, 105,
			15, 1}
	};

	// Binomial C(k, i)
	function automatic logic [12:0] binom(input logic [TIDX_W-1:0] k,
			input logic [TIDX_W-1:0] i);
		return PASCAL_TBL[k][i];
	endfunction

	// Clamp to the 48-bit signed range
	function automatic pse_sat_t sat48(input logic signed [63:0] v);
		pse_sat_t r;
		r.ovf = 1'b0;
		r.val = v[47:0];
		if (v > SAT_MAX) begin
			r.ovf = 1'b1;
			r.val = SAT_MAX[47:0];
		end else if (v < SAT_MIN) begin
			r.ovf = 1'b1;
			r.val = SAT_MIN[47:0];
		end
		return r;
	endfunction

endpackage

// ----- design/pse_ctrl.sv -----
// Sequencer of the polynomial shift engine: load, Horner phases, result handoff.
// Depends on pse_pkg; drives pse_datapath through pse_cmd_t.
module pse_ctrl #(
	parameter int MAX_TERMS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               coef_valid,
	input  logic               coef_last,
	output logic               coef_stall,
	input  pse_pkg::pse_stat_t stat,
	output pse_pkg::pse_cmd_t  cmd
);

	typedef enum logic [2:0] {
		S_LOAD,
		S_MAG,
		S_MLO,
		S_MHI,
		S_RND,
		S_ACC,
		S_EMIT
	} state_t;

	state_t                           state_q;
	logic [pse_pkg::TIDX_W-1:0]       row_q;
	logic [pse_pkg::TIDX_W-1:0]       term_q;
	logic [pse_pkg::TIDX_W-1:0]       last_q;
	logic [pse_pkg::TIDX_W-1:0]       n_m1;
	logic                             full;

	// Highest index of the set once the current request is stored
	assign full = (stat.term_count == pse_pkg::CNT_W'(MAX_TERMS));
	assign n_m1 = full ? pse_pkg::TIDX_W'(MAX_TERMS - 1)
	                   : stat.term_count[pse_pkg::TIDX_W-1:0];

	assign coef_stall = (state_q != S_LOAD);

	// Decode commands from the state
	always_comb begin
		cmd            = '0;
		cmd.op         = pse_pkg::OP_NONE;
		cmd.row        = row_q;
		cmd.term       = term_q;
		cmd.first_step = (term_q == last_q);
		cmd.last_row   = (row_q == last_q);
		unique case (state_q)
			S_LOAD: cmd.load = coef_valid;
			S_MAG:  cmd.op   = pse_pkg::OP_MAG;
			S_MLO:  cmd.op   = pse_pkg::OP_MLO;
			S_MHI:  cmd.op   = pse_pkg::OP_MHI;
			S_RND:  cmd.op   = pse_pkg::OP_RND;
			S_ACC:  cmd.op   = pse_pkg::OP_ACC;
			S_EMIT: cmd.emit = stat.out_free;
			default: cmd.op  = pse_pkg::OP_NONE;
		endcase
	end

	// Advance through rows and Horner steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			row_q   <= '0;
			term_q  <= '0;
			last_q  <= '0;
		end else begin
			unique case (state_q)
				S_LOAD: begin
					if (coef_valid && coef_last) begin
						last_q  <= n_m1;
						row_q   <= '0;
						term_q  <= n_m1;
						state_q <= S_MAG;
					end
				end
				S_MAG: state_q <= S_MLO;
				S_MLO: state_q <= S_MHI;
				S_MHI: state_q <= S_RND;
				S_RND: state_q <= S_ACC;
				S_ACC: begin
					if (term_q == row_q) begin
						state_q <= S_EMIT;
					end else begin
						term_q  <= term_q - 1'b1;
						state_q <= S_MAG;
					end
				end
				S_EMIT: begin
					if (stat.out_free) begin
						if (row_q == last_q) begin
							state_q <= S_LOAD;
						end else begin
							row_q   <= row_q + 1'b1;
							term_q  <= last_q;
							state_q <= S_MAG;
						end
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

endmodule

// ----- design/pse_datapath.sv -----
// Coefficient store, shared 24x32 multiplier, rounding, accumulator, result register.
// Depends on pse_pkg; commanded by pse_ctrl.
module pse_datapath #(
	parameter int MAX_TERMS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  pse_pkg::pse_cmd_t  cmd,
	input  pse_pkg::pse_in_t   coef,
	input  logic               result_stall,
	output pse_pkg::pse_stat_t stat,
	output logic               result_valid,
	output pse_pkg::pse_out_t  result
);

	localparam int IW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
	localparam int CW = $clog2(MAX_TERMS + 1);

	logic signed [47:0] store_q [MAX_TERMS];
	logic [CW-1:0]      count_q;
	logic               dropped_q;
	logic [31:0]        smag_q;
	logic               sneg_q;
	logic signed [47:0] acc_q;
	logic signed [47:0] term_q;
	logic signed [47:0] pk_q;
	logic [47:0]        mag_q;
	logic               neg_q;
	logic [55:0]        lo_q;
	logic [55:0]        hi_q;
	logic signed [48:0] prod_q;
	logic               ovf_q;
	logic               result_valid_q;
	pse_pkg::pse_out_t  result_q;

	logic               has_room;
	logic signed [47:0] acc_eff;
	logic [12:0]        c_ki;
	logic signed [61:0] tprod;
	pse_pkg::pse_sat_t  tsat;
	logic [23:0]        mul_a;
	logic [55:0]        mul_p;
	logic [63:0]        rnd_sum;
	logic [63:0]        lim;
	logic               rsat;
	logic [47:0]        rmag;
	logic signed [49:0] sum;
	pse_pkg::pse_sat_t  asat;
	logic               out_free;

	assign has_room = (count_q < CW'(MAX_TERMS));

	// Term C(k,i) * P[k], saturated; P[k] is read from the store in the first phase
	assign c_ki  = pse_pkg::binom(cmd.term, cmd.row);
	assign tprod = 62'($signed({1'b0, c_ki})) * 62'(pk_q);
	assign tsat  = pse_pkg::sat48(64'(tprod));

	// Accumulator starts from zero on the first step of a row
	assign acc_eff = cmd.first_step ? '0 : acc_q;

	// Shared multiplier: low half of |acc| then high half
	assign mul_a = (cmd.op == pse_pkg::OP_MHI) ? mag_q[47:24] : mag_q[23:0];
	assign mul_p = 56'(mul_a) * 56'(smag_q);

	// Recombine halves, round half away from zero, clamp magnitude
	assign rnd_sum = {hi_q, 8'd0} + 64'((57'(lo_q) + 57'h8000) >> 16);
	assign lim     = neg_q ? 64'h0000_8000_0000_0000 : 64'h0000_7FFF_FFFF_FFFF;
	assign rsat    = (rnd_sum > lim);
	assign rmag    = rsat ? lim[47:0] : rnd_sum[47:0];

	// Add the term and clamp
	assign sum  = 50'(prod_q) + 50'(term_q);
	assign asat = pse_pkg::sat48(64'(sum));

	assign out_free        = !result_valid_q || !result_stall;
	assign stat.out_free   = out_free;
	assign stat.term_count = pse_pkg::CNT_W'(count_q);
	assign result_valid    = result_valid_q;
	assign result          = result_q;

	// Write incoming coefficients
	always_ff @(posedge clk) begin
		if (cmd.load && has_room) begin
			store_q[count_q[IW-1:0]] <= coef.coefficient;
		end
	end

	// Track fill level and drops; clear after the last result of a set
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			dropped_q <= 1'b0;
		end else if (cmd.load) begin
			if (has_room) begin
				count_q <= count_q + 1'b1;
			end else begin
				dropped_q <= 1'b1;
			end
		end else if (cmd.emit && cmd.last_row) begin
			count_q   <= '0;
			dropped_q <= 1'b0;
		end
	end

	// Horner step phases
	always_ff @(posedge clk) begin
		if (cmd.load && coef.last_term) begin
			sneg_q <= coef.shift_amount[31];
			smag_q <= coef.shift_amount[31] ? (~coef.shift_amount + 32'd1)
			                                : coef.shift_amount;
		end
		case (cmd.op)
			pse_pkg::OP_MAG: begin
				pk_q  <= store_q[cmd.term[IW-1:0]];
				mag_q <= acc_eff[47] ? (~acc_eff + 48'd1) : acc_eff;
				neg_q <= acc_eff[47] ^ sneg_q;
				ovf_q <= cmd.first_step ? dropped_q : ovf_q;
			end
			pse_pkg::OP_MLO: begin
				lo_q   <= mul_p;
				term_q <= tsat.val;
				ovf_q  <= ovf_q | tsat.ovf;
			end
			pse_pkg::OP_MHI: hi_q <= mul_p;
			pse_pkg::OP_RND: begin
				prod_q <= neg_q ? -$signed({1'b0, rmag}) : $signed({1'b0, rmag});
				ovf_q  <= ovf_q | rsat;
			end
			pse_pkg::OP_ACC: begin
				acc_q <= asat.val;
				ovf_q <= ovf_q | asat.ovf;
			end
			default: ;
		endcase
	end

	// Result register payload
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			result_q.shifted_coefficient <= acc_q;
			result_q.end_of_set          <= cmd.last_row;
			result_q.overflow_flag       <= ovf_q;
		end
	end

	// Result valid: set on handoff, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

endmodule

// ----- design/polynomial_shift_engine.sv -----
// Polynomial shift engine: Taylor shift of a fixed-point polynomial.
// Loading takes one coefficient per cycle while the sequencer waits in its load state. After
// the last one, result i of an n-term set takes n-i Horner steps of five phases each around one
// shared 24x32 multiplier, then a handoff. The next set loads while the last result waits.
// Reset (arst_n, asynchronous) clears the fill count, drop flag, sequencer and result valid;
// the coefficient store is not cleared.
module polynomial_shift_engine #(
	parameter int MAX_TERMS = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              coef_valid,
	output logic              coef_stall,
	input  pse_pkg::pse_in_t  coef,
	output logic              result_valid,
	input  logic              result_stall,
	output pse_pkg::pse_out_t result
);

	pse_pkg::pse_cmd_t  cmd;
	pse_pkg::pse_stat_t stat;

	pse_ctrl #(
		.MAX_TERMS(MAX_TERMS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.coef_valid(coef_valid),
		.coef_last (coef.last_term),
		.coef_stall(coef_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	pse_datapath #(
		.MAX_TERMS(MAX_TERMS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.coef        (coef),
		.result_stall(result_stall),
		.stat        (stat),
		.result_valid(result_valid),
		.result      (result)
	);

	// A last coefficient starts the computation and blocks further requests
	a_last_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		coef_valid && !coef_stall && coef.last_term |=> coef_stall)
		else $error("coefficient accepted right after last term");

	// A handoff only happens into a free result register
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> stat.out_free)
		else $error("result handoff while result register busy");

	// A handoff always shows up as a valid result
	a_emit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> result_valid)
		else $error("handoff did not raise result valid");

	// No computation while a set is still loading
	a_no_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> (cmd.op == pse_pkg::OP_NONE) && !cmd.emit)
		else $error("load overlaps computation");

endmodule

// ----- sim/shift_checker.sv -----
`timescale 1ns / 1ps
// Checker for the polynomial shift engine: watches both channels, predicts results.
// Depends on pse_pkg for the request types; instantiated by the testbench top.
module shift_checker #(
	parameter int MAX_TERMS = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              coef_valid,
	input  logic              coef_stall,
	input  pse_pkg::pse_in_t  coef,
	input  logic              result_valid,
	input  logic              result_stall,
	input  pse_pkg::pse_out_t result,
	output int                fail_count,
	output int                pending
);

	localparam longint SAT_HI = 64'sh0000_7FFF_FFFF_FFFF;
	localparam longint SAT_LO = -SAT_HI - 1;
	localparam int PRINT_LIMIT = 20;

	// Predictor state: loaded terms of the current set
	logic signed [47:0] coef_store [MAX_TERMS];
	int                 coef_count;
	bit                 terms_dropped;
	pse_pkg::pse_out_t  shifted_terms_q [$];
	int                 results_seen;

	initial begin
		fail_count = 0;
		pending = 0;
		coef_count = 0;
		terms_dropped = 1'b0;
		results_seen = 0;
	end

	// Print one mismatch line, quietly count once the print limit is reached
	task automatic report_mismatch(input string what, input logic [47:0] got,
			input logic [47:0] want);
		if (fail_count < PRINT_LIMIT)
			$display("%0t: result %0d: %s: got %h, expected %h", $realtime, results_seen,
				what, got, want);
		fail_count++;
	endtask

	// Clamp to the 48-bit signed range, flag any clipping
	function automatic longint clamp48(input longint v, inout bit ovf);
		if (v > SAT_HI) begin
			ovf = 1'b1;
			return SAT_HI;
		end
		if (v < SAT_LO) begin
			ovf = 1'b1;
			return SAT_LO;
		end
		return v;
	endfunction

	// Multiply by the shift (16 fraction bits), round half away from zero, clamp
	function automatic longint scale_by_shift(input longint a, input longint s, inout bit ovf);
		logic [79:0] mag_a, mag_s, prod, lim;
		bit          neg;
		neg = (a < 0) != (s < 0);
		mag_a = (a < 0) ? 80'(-a) : 80'(a);
		mag_s = (s < 0) ? 80'(-s) : 80'(s);
		prod = (mag_a * mag_s + 80'h8000) >> 16;
		lim = neg ? 80'h8000_0000_0000 : 80'h7FFF_FFFF_FFFF;
		if (prod > lim) begin
			prod = lim;
			ovf = 1'b1;
		end
		return neg ? -longint'(prod[63:0]) : longint'(prod[63:0]);
	endfunction

	// Binomial C(k, i), exact at every step of the product
	function automatic longint binomial(input int k, input int i);
		longint c;
		c = 1;
		for (int j = 0; j < i; j++)
			c = c * (k - j) / (j + 1);
		return c;
	endfunction

	// Expand the stored set into its shifted coefficients, Horner order per result
	function automatic void shift_polynomial(input longint s);
		longint            acc, term;
		bit                ovf;
		pse_pkg::pse_out_t r;
		for (int i = 0; i < coef_count; i++) begin
			ovf = terms_dropped;
			acc = 0;
			for (int k = coef_count - 1; k >= i; k--) begin
				term = clamp48(binomial(k, i) * longint'(coef_store[k]), ovf);
				acc = clamp48(scale_by_shift(acc, s, ovf) + term, ovf);
			end
			r.shifted_coefficient = acc[47:0];
			r.end_of_set = (i == coef_count - 1);
			r.overflow_flag = ovf;
			shifted_terms_q = {shifted_terms_q, r};
		end
	endfunction

	// Store or drop one coefficient; on the last one, predict the whole set
	function automatic void absorb_coefficient(input pse_pkg::pse_in_t item);
		if (coef_count < MAX_TERMS) begin
			coef_store[coef_count] = item.coefficient;
			coef_count++;
		end else begin
			terms_dropped = 1'b1;
		end
		if (item.last_term) begin
			shift_polynomial(longint'(item.shift_amount));
			coef_count = 0;
			terms_dropped = 1'b0;
		end
	endfunction

	// Compare one result request with the oldest prediction
	task automatic check_result(input pse_pkg::pse_out_t got);
		pse_pkg::pse_out_t want;
		if (shifted_terms_q.size() == 0) begin
			report_mismatch("result with nothing expected", got.shifted_coefficient, '0);
		end else begin
			want = shifted_terms_q.pop_front();
			if (got.shifted_coefficient !== want.shifted_coefficient)
				report_mismatch("shifted_coefficient", got.shifted_coefficient,
					want.shifted_coefficient);
			if (got.end_of_set !== want.end_of_set)
				report_mismatch("end_of_set", 48'(got.end_of_set), 48'(want.end_of_set));
			if (got.overflow_flag !== want.overflow_flag)
				report_mismatch("overflow_flag", 48'(got.overflow_flag),
					48'(want.overflow_flag));
		end
		results_seen++;
	endtask

	// Sample both channels at the rising edge
	always @(posedge clk) begin
		if (!arst_n) begin
			coef_count = 0;
			terms_dropped = 1'b0;
			shifted_terms_q.delete();
		end else begin
			if (result_valid && !result_stall)
				check_result(result);
			if (coef_valid && !coef_stall)
				absorb_coefficient(coef);
		end
		pending = shifted_terms_q.size();
	end

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// Testbench top for the polynomial shift engine: clock, reset, stimulus and verdict.
// Depends on pse_pkg, polynomial_shift_engine and shift_checker.
module testbench;

	localparam int TERMS_DEPTH = 8;
	localparam int RANDOM_ITEMS = 300;
	localparam int IDLE_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 200;

	localparam logic signed [47:0] COEF_MAX = 48'sh7FFF_FFFF_FFFF;
	localparam logic signed [47:0] COEF_MIN = 48'sh8000_0000_0000;
	localparam logic signed [31:0] SHIFT_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] SHIFT_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] SHIFT_ONE = 32'sh0001_0000;

	typedef enum int {COEF_FULL, COEF_SMALL, COEF_EDGE} coef_mode_t;
	typedef enum int {SHIFT_FULL, SHIFT_SMALL, SHIFT_EDGE} shift_mode_t;
	typedef enum int {STALL_NONE, STALL_HALF, STALL_HEAVY, STALL_ALTERNATE} stall_mode_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              coef_valid = 1'b0;
	logic              coef_stall;
	pse_pkg::pse_in_t  coef = '0;
	logic              result_valid;
	logic              result_stall = 1'b0;
	pse_pkg::pse_out_t result;
	int                fail_count;
	int                pending;
	int                items_sent = 0;
	int                burst_left = 0;
	int                idle_cycles = 0;

	polynomial_shift_engine #(
		.MAX_TERMS(TERMS_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.coef_valid(coef_valid),
		.coef_stall(coef_stall),
		.coef(coef),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	shift_checker #(
		.MAX_TERMS(TERMS_DEPTH)
	) shift_check (
		.clk(clk),
		.arst_n(arst_n),
		.coef_valid(coef_valid),
		.coef_stall(coef_stall),
		.coef(coef),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.fail_count(fail_count),
		.pending(pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Draw a coefficient: full range, small magnitude, or an edge value
	function automatic logic signed [47:0] draw_coef(input coef_mode_t mode);
		logic signed [63:0] w;
		w = {$urandom(), $urandom()};
		case (mode)
			COEF_FULL:  return w[47:0];
			COEF_SMALL: return 48'(w >>> 27);
			default: begin
				case ($urandom_range(0, 3))
					0:       return COEF_MAX;
					1:       return COEF_MIN;
					2:       return '0;
					default: return '1;
				endcase
			end
		endcase
	endfunction

	// Draw a shift: full range, within about +-2.0, or an edge value
	function automatic logic signed [31:0] draw_shift(input shift_mode_t mode);
		logic signed [31:0] w;
		w = $urandom();
		case (mode)
			SHIFT_FULL:  return w;
			SHIFT_SMALL: return w >>> 14;
			default: begin
				case ($urandom_range(0, 4))
					0:       return SHIFT_MAX;
					1:       return SHIFT_MIN;
					2:       return '0;
					3:       return -SHIFT_ONE;
					default: return SHIFT_ONE;
				endcase
			end
		endcase
	endfunction

	// Send one coefficient request; called and returns at a falling edge
	task automatic send_term(input logic signed [47:0] value, input logic signed [31:0] shift,
			input logic last);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				coef_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
				: $urandom_range(1, 16);
		end
		burst_left--;
		coef <= '{coefficient: value, shift_amount: shift, last_term: last};
		coef_valid <= 1'b1;
		do @(posedge clk); while (coef_stall);
		items_sent++;
		@(negedge clk);
	endtask

	// Send a set of len coefficients, the shift riding on the last one
	task automatic send_set(input int len, input coef_mode_t mode,
			input logic signed [31:0] shift);
		for (int j = 0; j < len; j++) begin
			if (j == len - 1)
				send_term(draw_coef(mode), shift, 1'b1);
			else
				send_term(draw_coef(mode), $urandom(), 1'b0);
		end
	endtask

	// Stall the result side in segments of random style
	stall_mode_t stall_mode = STALL_NONE;
	int          stall_left = 0;
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode = stall_mode_t'($urandom_range(0, 3));
			stall_left = $urandom_range(10, 80);
		end
		stall_left--;
		case (stall_mode)
			STALL_NONE:  result_stall <= 1'b0;
			STALL_HALF:  result_stall <= 1'($urandom_range(0, 1));
			STALL_HEAVY: result_stall <= ($urandom_range(0, 9) < 8);
			default:     result_stall <= ~result_stall;
		endcase
	end

	// Abort when neither channel moves for too long
	always @(posedge clk) begin
		if ((coef_valid && !coef_stall) || (result_valid && !result_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("[polynomial_shift_engine] ERROR");
			$finish;
		end
	end

	initial begin
		int          len;
		int          pick;
		coef_mode_t  cmode;
		shift_mode_t smode;

		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Single-term sets at the extremes: the result is the coefficient itself
		send_term(COEF_MAX, SHIFT_MIN, 1'b1);
		send_term(COEF_MIN, SHIFT_MAX, 1'b1);
		// Two terms driven into saturation
		send_term(COEF_MIN, $urandom(), 1'b0);
		send_term(COEF_MAX, SHIFT_MIN, 1'b1);
		// Zero shift leaves the polynomial unchanged
		send_term('1, $urandom(), 1'b0);
		send_term(48'sd1, '0, 1'b1);
		// Full store with the largest shift
		send_set(TERMS_DEPTH, COEF_SMALL, SHIFT_MAX);
		// Overfull set: extra terms dropped and flagged
		send_set(TERMS_DEPTH + 2, COEF_FULL, SHIFT_ONE);

		// Random sets, mostly small values so results stay meaningful
		while (items_sent < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 9);
			if (pick == 0)
				len = 1;
			else if (pick == 8)
				len = TERMS_DEPTH;
			else if (pick == 9)
				len = $urandom_range(TERMS_DEPTH + 1, TERMS_DEPTH + 4);
			else
				len = $urandom_range(1, TERMS_DEPTH);
			pick = $urandom_range(0, 5);
			cmode = (pick == 0) ? COEF_FULL : (pick == 1) ? COEF_EDGE : COEF_SMALL;
			pick = $urandom_range(0, 5);
			smode = (pick == 0) ? SHIFT_FULL : (pick == 1) ? SHIFT_EDGE : SHIFT_SMALL;
			send_set(len, cmode, draw_shift(smode));
		end
		coef_valid <= 1'b0;

		// Drain every expected result, then watch a while for strays
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (fail_count == 0)
			$display("[polynomial_shift_engine] OK");
		else
			$display("[polynomial_shift_engine] ERROR");
		$finish;
	end

endmodule

// ----- files.f -----
design/pse_pkg.sv
design/pse_ctrl.sv
design/pse_datapath.sv
design/polynomial_shift_engine.sv
sim/shift_checker.sv
sim/testbench.sv
